// ===== sv/double_ended_queue_assert.svh =====
// Assertion macros shared by the double-ended queue RTL.
// Each macro expects a clock named clk and a reset named rst in the module that uses it.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequence holds in the cycle after a trigger.
`define DEQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// Package for the double-ended queue: payload structs, command and status codes.
// No dependencies; imported by deq_store, double_ended_queue and double_ended_queue_test.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEQ_DEPTH = 16;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
  } deq_out_t;

endpackage

// ===== sv/deq_store.sv =====
// Entry store of the double-ended queue: one write port and one registered read port.
// Depends on deq_pkg for the default depth.
`timescale 1ns / 1ps

module deq_store import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  logic signed [31:0]  wdata,
  input  logic                re,
  input  logic [IW-1:0]       raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// Double-ended queue: a push result is registered and shown in the cycle after the
// transaction; a pop on a non-empty queue passes S_READ first, as the single registered
// read port of the store sets it. A list reads its next entry once each result is taken.
// A new command is accepted only after the last result of the previous one was taken.
// Synchronous reset empties the queue (front and count cleared); store contents are kept.
`timescale 1ns / 1ps

module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_out_t out_data
);

  `include "double_ended_queue_assert.svh"

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [IW-1:0]   front, front_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;
  logic            listing, listing_next;
  deq_out_t        out_reg, out_reg_next;

  logic [IW-1:0]   offset;
  logic [IW:0]     slot_sum;
  logic [IW-1:0]   slot;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   count_dec;
  logic            full, empty, accept;

  logic                we, re;
  logic [IW-1:0]       waddr, raddr;
  logic signed [31:0]  wdata, rdata;

  deq_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = out_reg;
  assign accept    = in_valid & in_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign idx_inc   = idx + 1'b1;
  assign count_dec = count - 1'b1;

  // Shared circular index adder: slot = (front + offset) mod DEPTH.
  always_comb begin
    offset = '0;
    if (state == S_OUT) begin
      offset = idx_inc[IW-1:0];
    end else begin
      case (in_data.cmd)
        CMD_PUSH_FRONT: offset = IW'(DEPTH - 1);
        CMD_PUSH_BACK:  offset = count[IW-1:0];
        CMD_POP_FRONT:  offset = IW'(1);
        CMD_POP_BACK:   offset = count_dec[IW-1:0];
        default:        offset = '0;
      endcase
    end
  end

  assign slot_sum = {1'b0, front} + {1'b0, offset};
  assign slot = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
                                             : slot_sum[IW-1:0];

  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    idx_next     = idx;
    listing_next = listing;
    out_reg_next = out_reg;
    we    = 1'b0;
    waddr = slot;
    wdata = in_data.push_value;
    re    = 1'b0;
    raddr = slot;

    case (state)
      S_IDLE: begin
        if (accept) begin
          listing_next = 1'b0;
          case (in_data.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              state_next = S_OUT;
              if (full) begin
                out_reg_next = '{out_value: '0, status: ST_FULL, last: 1'b1};
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
                if (in_data.cmd == CMD_PUSH_FRONT) begin
                  front_next = slot;
                end
                out_reg_next = '{out_value: in_data.push_value, status: ST_OK, last: 1'b1};
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_LIST: begin
              if (empty) begin
                state_next   = S_OUT;
                out_reg_next = '{out_value: '0, status: ST_EMPTY, last: 1'b1};
              end else begin
                state_next = S_READ;
                re         = 1'b1;
                if (in_data.cmd == CMD_POP_FRONT) begin
                  raddr      = front;
                  front_next = slot;
                  count_next = count_dec;
                end else if (in_data.cmd == CMD_POP_BACK) begin
                  count_next = count_dec;
                end else begin
                  raddr        = front;
                  idx_next     = '0;
                  listing_next = 1'b1;
                end
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        state_next             = S_OUT;
        out_reg_next.out_value = rdata;
        out_reg_next.status    = ST_OK;
        out_reg_next.last      = listing ? (idx_inc == count) : 1'b1;
      end
      S_OUT: begin
        if (out_ready) begin
          if (listing && !out_reg.last) begin
            idx_next   = idx_inc;
            re         = 1'b1;
            state_next = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      front   <= '0;
      count   <= '0;
      idx     <= '0;
      listing <= 1'b0;
    end else begin
      state   <= state_next;
      front   <= front_next;
      count   <= count_next;
      idx     <= idx_next;
      listing <= listing_next;
    end
    out_reg <= out_reg_next;
  end

  `DEQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `DEQ_ASSERT_ALWAYS(a_ready_xor_valid, !(in_ready && out_valid), "ready while result pending")
  `DEQ_ASSERT_ALWAYS(a_error_result, !out_valid || out_data.status == ST_OK || (out_data.out_value == '0 && out_data.last), "error result not zero and final")
  `DEQ_ASSERT_NEXT(a_pop_empty, accept && (in_data.cmd == CMD_POP_FRONT || in_data.cmd == CMD_POP_BACK) && empty, out_valid && out_data.status == ST_EMPTY, "pop on empty queue not flagged")
  `DEQ_ASSERT_NEXT(a_push_full, accept && (in_data.cmd == CMD_PUSH_FRONT || in_data.cmd == CMD_PUSH_BACK) && full, out_valid && out_data.status == ST_FULL && $stable(count) && $stable(front), "push into full queue changed state")

endmodule

// ===== dv/double_ended_queue_test.sv =====
// Self-checking testbench for double_ended_queue: drives push, pop, list and ignored commands
// with random idle gaps on both channels and checks each result against a mirror queue.
// Depends on deq_pkg for the payload structs and the command and status codes.
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEQ_DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  // Random groups are added until the backlog holds at least this many commands.
  localparam int ITEM_TARGET = 100;

  // Command codes the block ignores.
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    deq_in_t cmd_item;
    logic    wait_drain;
  } send_item_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  deq_out_t out_data;

  send_item_t  cmd_backlog[$];
  deq_out_t    expected_results[$];

  // Mirror of the queue contents.
  logic signed [31:0] mirror_store [DEQ_DEPTH];
  logic [IDX_W-1:0]   mirror_front = '0;
  logic [IDX_W:0]     mirror_count = '0;

  int          err_count = 0;
  int          cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned ready_hold = 0;
  int unsigned ready_calm = 0;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int unsigned pick_idle(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      calm = $urandom_range(60, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_expected(logic signed [31:0] v, logic [1:0] st, logic lst);
    expected_results.push_back('{out_value: v, status: st, last: lst});
  endfunction

  function automatic void predict_deq(deq_in_t t);
    int i;
    case (t.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (mirror_count >= DEQ_DEPTH) begin
          add_expected('0, ST_FULL, 1'b1);
        end else begin
          if (t.cmd == CMD_PUSH_FRONT) begin
            mirror_front = IDX_W'((int'(mirror_front) + DEQ_DEPTH - 1) % DEQ_DEPTH);
            mirror_store[mirror_front] = t.push_value;
          end else begin
            mirror_store[IDX_W'((int'(mirror_front) + int'(mirror_count)) % DEQ_DEPTH)] =
              t.push_value;
          end
          mirror_count++;
          add_expected(t.push_value, ST_OK, 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (mirror_count == 0) begin
          add_expected('0, ST_EMPTY, 1'b1);
        end else begin
          add_expected(mirror_store[mirror_front], ST_OK, 1'b1);
          mirror_front = IDX_W'((int'(mirror_front) + 1) % DEQ_DEPTH);
          mirror_count--;
        end
      end
      CMD_POP_BACK: begin
        if (mirror_count == 0) begin
          add_expected('0, ST_EMPTY, 1'b1);
        end else begin
          add_expected(mirror_store[IDX_W'((int'(mirror_front) + int'(mirror_count) - 1)
                                           % DEQ_DEPTH)],
                       ST_OK, 1'b1);
          mirror_count--;
        end
      end
      CMD_LIST: begin
        if (mirror_count == 0) begin
          add_expected('0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < int'(mirror_count); i++) begin
            add_expected(mirror_store[IDX_W'((int'(mirror_front) + i) % DEQ_DEPTH)], ST_OK,
                         (i + 1 == int'(mirror_count)));
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_cmd(logic [2:0] c, logic [31:0] v, logic hold);
    cmd_backlog.push_back('{cmd_item: '{cmd: c, push_value: v}, wait_drain: hold});
  endfunction

  // Driver: one command transaction at a time from the backlog.
  always @(posedge clk) begin
    send_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_deq(in_data);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0 && cmd_backlog[0].wait_drain &&
                     expected_results.size() > 0) begin
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          in_data <= nxt.cmd_item;
          in_valid <= 1'b1;
          send_gap = pick_idle(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and throttles out_ready.
  always @(posedge clk) begin
    deq_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: value %0d status %0d last %0d",
                     out_data.out_value, out_data.status, out_data.last);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch (exp/got): value %0d/%0d status %0d/%0d last %0d/%0d",
                       want.out_value, out_data.out_value, want.status, out_data.status,
                       want.last, out_data.last);
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(3) == 0) ready_hold = pick_idle(ready_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  initial begin
    int seq;
    int len;
    int k;
    int unsigned kind;
    logic hold;

    // Directed: empty cases, ignored codes, extreme values, then fill past full, list and pop both ends.
    add_cmd(CMD_LIST, pick_value(), 1'b0);
    add_cmd(CMD_POP_FRONT, 32'hFFFF_FFFF, 1'b0);
    add_cmd(CMD_POP_BACK, 32'h8000_0000, 1'b0);
    add_cmd(CMD_RSVD5, 32'hFFFF_FFFF, 1'b0);
    add_cmd(CMD_RSVD6, 32'h5555_5555, 1'b0);
    add_cmd(CMD_RSVD7, 32'hAAAA_AAAA, 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
    add_cmd(CMD_PUSH_BACK, 32'h8000_0000, 1'b0);
    add_cmd(CMD_LIST, 32'h0, 1'b0);
    for (k = 0; k < DEQ_DEPTH - 2; k++)
      add_cmd((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value(), 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'h1234_5678, 1'b0);
    add_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
    add_cmd(CMD_LIST, 32'h0, 1'b0);
    add_cmd(CMD_POP_FRONT, 32'h0, 1'b0);
    add_cmd(CMD_POP_BACK, 32'h0, 1'b0);

    // Random: fill and drain runs, mixed runs and ignored-code runs, so the queue wraps and reaches both ends often.
    seq = 0;
    while (cmd_backlog.size() < ITEM_TARGET) begin
      hold = (seq % 4 == 0);
      kind = $urandom_range(9);
      if (kind <= 3) begin
        len = $urandom_range(20, 4);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(5) == 0) add_cmd(CMD_LIST, pick_value(), hold);
          else add_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value(), hold);
          hold = 1'b0;
        end
      end else if (kind <= 6) begin
        len = $urandom_range(18, 2);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(7) == 0) add_cmd(CMD_LIST, pick_value(), hold);
          else add_cmd($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_value(), hold);
          hold = 1'b0;
        end
      end else if (kind <= 8) begin
        len = $urandom_range(10, 3);
        for (k = 0; k < len; k++) begin
          add_cmd(3'($urandom_range(CMD_LIST, CMD_PUSH_FRONT)), pick_value(), hold);
          hold = 1'b0;
        end
      end else begin
        len = $urandom_range(3, 1);
        for (k = 0; k < len; k++) begin
          add_cmd(3'($urandom_range(CMD_RSVD7, CMD_RSVD5)), pick_value(), hold);
          hold = 1'b0;
        end
        add_cmd(CMD_LIST, pick_value(), 1'b0);
      end
      seq++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) err_count++;

    if (err_count == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
